// ===== rtl/core/cursor_array_list_top_defines.svh =====
// Assertion macros for the cursor array list block.
// Used by cursor_array_list_top; needs a clock and an active-low reset in scope.
`ifndef CURSOR_ARRAY_LIST_TOP_DEFINES_SVH
`define CURSOR_ARRAY_LIST_TOP_DEFINES_SVH

// Clocked assertion with explicit clock and active-low reset.
`define CAL_ASSERT_CLK(clk, rst_n, lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion on the block clock and reset.
`define CAL_ASSERT(lbl, prop, msg) \
    `CAL_ASSERT_CLK(i_clk, i_rst_n, lbl, prop, msg)

`endif

// ===== rtl/core/cal_pkg.sv =====
// Package for the cursor array list: field widths, command, status and action codes.
// No dependencies.
package cal_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int DATA_W_DEF = 32;

    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int RDATA_W  = 32;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 11;
    localparam int CURPOS_W = 10;
    localparam int ACT_W    = 3;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ACT_W-1:0]    t_act;

    localparam t_cmd CMD_INS_BEFORE = 4'd0;
    localparam t_cmd CMD_INS_AFTER  = 4'd1;
    localparam t_cmd CMD_DELETE     = 4'd2;
    localparam t_cmd CMD_PREV       = 4'd3;
    localparam t_cmd CMD_NEXT       = 4'd4;
    localparam t_cmd CMD_START      = 4'd5;
    localparam t_cmd CMD_END        = 4'd6;
    localparam t_cmd CMD_RD_CUR     = 4'd7;
    localparam t_cmd CMD_WR_CUR     = 4'd8;
    localparam t_cmd CMD_RD_IDX     = 4'd9;
    localparam t_cmd CMD_WR_IDX     = 4'd10;

    localparam t_status ST_OK     = 3'd0;
    localparam t_status ST_EMPTY  = 3'd1;
    localparam t_status ST_BADIDX = 3'd2;
    localparam t_status ST_FULL   = 3'd3;
    localparam t_status ST_BOUND  = 3'd4;

    // What the datapath does with an accepted command.
    localparam t_act ACT_NONE = 3'd0;  // result at once, store untouched
    localparam t_act ACT_PUT  = 3'd1;  // single store write, result at once
    localparam t_act ACT_READ = 3'd2;  // single store read
    localparam t_act ACT_SHUP = 3'd3;  // move elements up, then write the new word
    localparam t_act ACT_SHDN = 3'd4;  // move elements down

    typedef struct packed {
        t_status status;
        t_act    act;
    } t_dec;

endpackage

// ===== rtl/core/cal_if.sv =====
// Valid/ready channel interfaces for the cursor array list: command in, result out.
// Depends on cal_pkg.
interface cal_cmd_if import cal_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface cal_res_if import cal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RDATA_W-1:0]  read_data;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
    logic [CURPOS_W-1:0] cursor_pos;

    modport source (output valid, output read_data, output status, output length,
                    output cursor_pos, input ready);
    modport sink   (input valid, input read_data, input status, input length,
                    input cursor_pos, output ready);
endinterface

// ===== rtl/core/cal_decode.sv =====
// Command decoder: status, datapath action, next count and cursor, store addresses.
// Depends on cal_pkg.
module cal_decode import cal_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  t_cmd                           i_cmd,
    input  logic [POS_W-1:0]               i_pos,
    input  logic [$clog2(DEPTH+1)-1:0]     i_count,
    input  logic [$clog2(DEPTH)-1:0]       i_cursor,
    output t_dec                           o_dec,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic [$clog2(DEPTH)-1:0]       o_cursor,
    output logic [$clog2(DEPTH)-1:0]       o_addr,
    output logic [$clog2(DEPTH)-1:0]       o_stop
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic             empty, full;
    logic [CNT_W-1:0] cur_ext, cur_p1, count_m1;
    logic [AW-1:0]    last;
    logic [CMP_W-1:0] pos_ext, cnt_cmp;

    assign empty    = (i_count == '0);
    assign full     = (i_count == CNT_W'(DEPTH));
    assign cur_ext  = CNT_W'(i_cursor);
    assign cur_p1   = cur_ext + 1'b1;
    assign count_m1 = i_count - 1'b1;
    assign last     = count_m1[AW-1:0];
    assign pos_ext  = CMP_W'(i_pos);
    assign cnt_cmp  = CMP_W'(i_count);

    always_comb begin
        o_dec.status = ST_OK;
        o_dec.act    = ACT_NONE;
        o_count      = i_count;
        o_cursor     = i_cursor;
        o_addr       = i_cursor;
        o_stop       = i_cursor;
        unique case (i_cmd) inside
            CMD_INS_BEFORE, CMD_INS_AFTER: begin
                if (full) begin
                    o_dec.status = ST_FULL;
                end else if (empty) begin
                    o_dec.act = ACT_PUT;
                    o_addr    = '0;
                    o_count   = CNT_W'(1);
                    o_cursor  = '0;
                end else if (i_cmd == CMD_INS_BEFORE) begin
                    o_dec.act = ACT_SHUP;
                    o_addr    = last;
                    o_stop    = i_cursor;
                    o_count   = i_count + 1'b1;
                    o_cursor  = i_cursor + 1'b1;
                end else begin
                    o_count = i_count + 1'b1;
                    if (cur_p1 == i_count) begin
                        // cursor on the last element: append, nothing to move
                        o_dec.act = ACT_PUT;
                        o_addr    = cur_p1[AW-1:0];
                    end else begin
                        o_dec.act = ACT_SHUP;
                        o_addr    = last;
                        o_stop    = cur_p1[AW-1:0];
                    end
                end
            end
            CMD_DELETE: begin
                if (empty) begin
                    o_dec.status = ST_EMPTY;
                end else begin
                    o_count = count_m1;
                    if (cur_ext == count_m1) begin
                        o_cursor = (i_cursor != '0) ? i_cursor - 1'b1 : '0;
                    end else begin
                        o_dec.act = ACT_SHDN;
                        o_addr    = cur_p1[AW-1:0];
                        o_stop    = last;
                    end
                end
            end
            CMD_PREV: begin
                if (i_cursor == '0) o_dec.status = ST_BOUND;
                else                o_cursor     = i_cursor - 1'b1;
            end
            CMD_NEXT: begin
                if (cur_p1 >= i_count) o_dec.status = ST_BOUND;
                else                   o_cursor     = i_cursor + 1'b1;
            end
            CMD_START: o_cursor = '0;
            CMD_END:   o_cursor = empty ? '0 : last;
            CMD_RD_CUR, CMD_WR_CUR: begin
                if (empty) begin
                    o_dec.status = ST_EMPTY;
                end else begin
                    o_dec.act = (i_cmd == CMD_RD_CUR) ? ACT_READ : ACT_PUT;
                    o_addr    = i_cursor;
                end
            end
            CMD_RD_IDX, CMD_WR_IDX: begin
                if (pos_ext >= cnt_cmp) begin
                    o_dec.status = ST_BADIDX;
                end else begin
                    o_dec.act = (i_cmd == CMD_RD_IDX) ? ACT_READ : ACT_PUT;
                    o_addr    = pos_ext[AW-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/cursor_array_list_top.sv =====
// Cursor array list: element store, count, cursor, shift sequencer, result register.
// Depends on cal_pkg, cal_if, cal_decode and cursor_array_list_top_defines.svh.
//
// Usage: one command item enters on i_cmd (cmd, value, position); exactly one
// result item leaves on o_res (read_data, status, length, cursor_pos). Both are
// valid/ready channels; an item moves on a clock edge with valid and ready high.
// From accept to result valid:
//   cursor moves, failing commands, writes, simple appends : registered at accept
//   reads (at cursor or by index)                          : store read, then READ
//   insert or delete that moves N elements                 : SHIFT, FLUSH, PUT, DONE
// PUT runs on insert only. A full shift moves DEPTH-1 elements; shifts are paced by
// the single read and single write port of the element store: one element moves
// per cycle, read in one cycle and written back one slot over in the next.
// One command is in work at a time. i_cmd.ready is high when the sequencer is
// idle and the result register is empty or being drained in that cycle.
// When the receiver stalls, the result holds in the output register and a
// finished multi-cycle command waits for it to drain before it is posted.
// Reset (synchronous, active low) empties the list, puts the cursor at 0 and
// drops any pending result; store contents are not cleared, since the count
// keeps every read within words already written.
`include "cursor_array_list_top_defines.svh"

module cursor_array_list_top import cal_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cal_cmd_if.sink   i_cmd,
    cal_res_if.source o_res
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;  // stream elements one slot over
    localparam logic [2:0] ST_FLUSH = 3'd2;  // last moved element written
    localparam logic [2:0] ST_PUT   = 3'd3;  // new word into the opened gap
    localparam logic [2:0] ST_DONE  = 3'd4;  // post result when output is free
    localparam logic [2:0] ST_READ  = 3'd5;  // read data back from store

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_cursor, n_cursor;

    // shift bookkeeping
    logic [AW-1:0]     r_ptr, n_ptr;       // next read address
    logic [AW-1:0]     r_stop, n_stop;     // last read address / gap for insert
    logic [AW-1:0]     r_paddr, n_paddr;   // address whose data sits in r_rdata
    logic              r_pend, n_pend;     // r_rdata still to be written back
    logic              r_up, n_up;         // shift direction
    logic [DATA_W-1:0] r_val, n_val;

    // element store, one write and one registered read port
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    // result register
    logic                r_o_valid, n_o_valid;
    logic [RDATA_W-1:0]  r_o_rdata, n_o_rdata;
    t_status             r_o_status, n_o_status;
    logic [LEN_W-1:0]    r_o_len, n_o_len;
    logic [CURPOS_W-1:0] r_o_cur, n_o_cur;

    logic              out_free, in_ready, in_acc;
    logic              emit;
    logic [DATA_W-1:0] emit_data;
    t_status           emit_status;
    logic [DATA_W-1:0] val_d;

    t_dec              dec;
    logic [CNT_W-1:0]  dec_count;
    logic [AW-1:0]     dec_cursor, dec_addr, dec_stop;
    logic [CNT_W-1:0]  cur_chk;

    assign out_free = !r_o_valid || o_res.ready;
    assign in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc   = i_cmd.valid && in_ready;
    assign val_d    = DATA_W'(i_cmd.value);
    assign cur_chk  = CNT_W'(r_cursor);

    assign i_cmd.ready      = in_ready;
    assign o_res.valid      = r_o_valid;
    assign o_res.read_data  = r_o_rdata;
    assign o_res.status     = r_o_status;
    assign o_res.length     = r_o_len;
    assign o_res.cursor_pos = r_o_cur;

    cal_decode #(
        .DEPTH (DEPTH)
    ) u_decode (
        .i_cmd    (i_cmd.cmd),
        .i_pos    (i_cmd.position),
        .i_count  (r_count),
        .i_cursor (r_cursor),
        .o_dec    (dec),
        .o_count  (dec_count),
        .o_cursor (dec_cursor),
        .o_addr   (dec_addr),
        .o_stop   (dec_stop)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_ptr       = r_ptr;
        n_stop      = r_stop;
        n_paddr     = r_paddr;
        n_pend      = r_pend;
        n_up        = r_up;
        n_val       = r_val;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_up ? r_paddr + 1'b1 : r_paddr - 1'b1;
        mem_raddr   = r_ptr;
        mem_wdata   = r_rdata;
        emit        = 1'b0;
        emit_data   = '0;
        emit_status = ST_OK;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // count and cursor commit at accept; the shift works from r_ptr/r_stop
                    n_count  = dec_count;
                    n_cursor = dec_cursor;
                    n_val    = val_d;
                    n_ptr    = dec_addr;
                    n_stop   = dec_stop;
                    n_pend   = 1'b0;
                    unique case (dec.act)
                        ACT_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = dec_addr;
                            mem_wdata = val_d;
                            emit      = 1'b1;
                        end
                        ACT_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = dec_addr;
                            n_state   = ST_READ;
                        end
                        ACT_SHUP: begin
                            n_up    = 1'b1;
                            n_state = ST_SHIFT;
                        end
                        ACT_SHDN: begin
                            n_up    = 1'b0;
                            n_state = ST_SHIFT;
                        end
                        default: begin
                            emit        = 1'b1;
                            emit_status = dec.status;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // read one element per cycle, write the previous one a slot over
                mem_re  = 1'b1;
                mem_we  = r_pend;
                n_pend  = 1'b1;
                n_paddr = r_ptr;
                if (r_ptr == r_stop) n_state = ST_FLUSH;
                else                 n_ptr   = r_up ? r_ptr - 1'b1 : r_ptr + 1'b1;
            end
            ST_FLUSH: begin
                mem_we  = 1'b1;
                n_pend  = 1'b0;
                n_state = r_up ? ST_PUT : ST_DONE;
            end
            ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_stop;
                mem_wdata = r_val;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_data = r_rdata;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_o_valid  = r_o_valid && !o_res.ready;
        n_o_rdata  = r_o_rdata;
        n_o_status = r_o_status;
        n_o_len    = r_o_len;
        n_o_cur    = r_o_cur;
        if (emit) begin
            n_o_valid  = 1'b1;
            n_o_rdata  = RDATA_W'(emit_data);
            n_o_status = emit_status;
            n_o_len    = LEN_W'(n_count);
            n_o_cur    = CURPOS_W'(n_cursor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_stop     <= n_stop;
        r_paddr    <= n_paddr;
        r_up       <= n_up;
        r_val      <= n_val;
        r_o_rdata  <= n_o_rdata;
        r_o_status <= n_o_status;
        r_o_len    <= n_o_len;
        r_o_cur    <= n_o_cur;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    // cursor stays inside the list, at 0 when empty
    `CAL_ASSERT(a_cursor_in_list, (r_count == '0 && r_cursor == '0) || (cur_chk < r_count), "cursor outside list")
    // an upward shift walks down to its stop, a downward shift up to it
    `CAL_ASSERT(a_shup_range, (r_state == ST_SHIFT && r_up) |-> (r_ptr >= r_stop), "shift up overran")
    `CAL_ASSERT(a_shdn_range, (r_state == ST_SHIFT && !r_up) |-> (r_ptr <= r_stop), "shift down overran")
    // the last element read in a shift is always written back
    `CAL_ASSERT(a_flush_pending, (r_state == ST_SHIFT && r_ptr == r_stop) |=> (r_state == ST_FLUSH && r_pend), "lost last element")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for cursor_array_list_top: command items in, result items out.
// Depends on cal_pkg, cal_cmd_if, cal_res_if and the RTL of cursor_array_list_top.
module tb;
    import cal_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int DATA_W       = DATA_W_DEF;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int MAX_WAIT     = 14;         // longest idle draw on either side
    localparam int RANDOM_ITEMS = 580;
    localparam int SEGMENT_LEN  = 40;         // random items per traffic profile
    localparam int DRAIN_CYCLES = DEPTH + 16; // a full shift plus margin
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int REPORT_MAX   = 10;

    // Codes with no command behind them; the block answers ok and changes nothing.
    localparam t_cmd CMD_UNUSED_LO = 4'd11;
    localparam t_cmd CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [RDATA_W-1:0]  read_data;
        t_status             status;
        logic [LEN_W-1:0]    length;
        logic [CURPOS_W-1:0] cursor_pos;
    } t_list_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cal_cmd_if cmd_if ();
    cal_res_if res_if ();

    cursor_array_list_top #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the list: words, count and cursor.
    logic [DATA_W-1:0] list_words [DEPTH];
    int                list_len  = 0;
    int                list_cur  = 0;
    int                peak_len  = 0;

    t_list_result predicted_results [$];

    int cmd_gap_max     = MAX_WAIT;  // 0 gives a back-to-back stretch
    int res_stall_max   = MAX_WAIT;
    int items_sent      = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int cycle_count     = 0;

    // Apply one accepted command to the shadow list and queue its result.
    function automatic void predict_command(t_cmd c, logic [VALUE_W-1:0] v,
                                            logic [POS_W-1:0] p);
        t_list_result r;
        int           at;
        int           i;
        r.read_data = '0;
        r.status    = ST_OK;
        case (c)
            CMD_INS_BEFORE, CMD_INS_AFTER: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (list_len == 0) begin
                    list_words[0] = v[DATA_W-1:0];
                    list_len      = 1;
                    list_cur      = 0;
                end else begin
                    // before: new word takes the cursor slot, cursor follows its element
                    at = (c == CMD_INS_BEFORE) ? list_cur : list_cur + 1;
                    for (i = list_len; i > at; i--)
                        list_words[i] = list_words[i-1];
                    list_words[at] = v[DATA_W-1:0];
                    list_len++;
                    if (c == CMD_INS_BEFORE)
                        list_cur++;
                end
            end
            CMD_DELETE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = list_cur; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    // last element gone: step back, but never below 0
                    if (list_cur == list_len && list_cur > 0)
                        list_cur--;
                end
            end
            CMD_PREV: begin
                if (list_cur == 0)
                    r.status = ST_BOUND;
                else
                    list_cur--;
            end
            CMD_NEXT: begin
                if (list_len == 0 || list_cur + 1 >= list_len)
                    r.status = ST_BOUND;
                else
                    list_cur++;
            end
            CMD_START: list_cur = 0;
            CMD_END:   list_cur = (list_len == 0) ? 0 : list_len - 1;
            CMD_RD_CUR, CMD_WR_CUR: begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (c == CMD_RD_CUR)
                    r.read_data = RDATA_W'(list_words[list_cur]);
                else
                    list_words[list_cur] = v[DATA_W-1:0];
            end
            CMD_RD_IDX, CMD_WR_IDX: begin
                if (p >= list_len)
                    r.status = ST_BADIDX;
                else if (c == CMD_RD_IDX)
                    r.read_data = RDATA_W'(list_words[p]);
                else
                    list_words[p] = v[DATA_W-1:0];
            end
            default: ;
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        r.length     = LEN_W'(list_len);
        r.cursor_pos = CURPOS_W'(list_cur);
        predicted_results.push_back(r);
    endfunction

    // Send one command item: random idle gap, then hold valid until accepted.
    // Called at a rising edge; valid gets one nonblocking write per step.
    task automatic send_item(t_cmd c, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        int gap;
        gap = $urandom_range(0, cmd_gap_max);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.cmd      <= c;
        cmd_if.value    <= v;
        cmd_if.position <= p;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        items_sent++;
        predict_command(c, v, p);
    endtask

    // Drop valid, hold off until every queued result has come back, then let
    // a full shift's worth of cycles pass so nothing is still in work.
    task automatic wait_results_drained();
        cmd_if.valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Every command but the inserts on an empty list, plus the unused codes.
    task automatic test_empty_list();
        send_item(CMD_DELETE, 32'h0, '0);
        send_item(CMD_RD_CUR, 32'h0, '0);
        send_item(CMD_WR_CUR, 32'hFFFF_FFFF, '1);
        send_item(CMD_PREV,   32'h0, '0);
        send_item(CMD_NEXT,   32'h0, '0);
        send_item(CMD_START,  32'h0, '0);
        send_item(CMD_END,    32'h0, '0);     // end of empty list keeps cursor at 0
        send_item(CMD_RD_IDX, 32'h0, '0);
        send_item(CMD_WR_IDX, 32'hFFFF_FFFF, '1);
        send_item(CMD_UNUSED_LO, 32'hFFFF_FFFF, '1);
        send_item(CMD_UNUSED_HI, 32'h0, '0);
    endtask

    // Short hand-built list: inserts on both sides, moves, reads, writes, deletes.
    task automatic test_edit_ops();
        send_item(CMD_INS_BEFORE, 32'h0000_0000, '0);  // empty list -> element 0
        send_item(CMD_INS_AFTER,  32'hFFFF_FFFF, '0);
        send_item(CMD_NEXT,       32'h0, '0);
        send_item(CMD_NEXT,       32'h0, '0);          // already on last element
        send_item(CMD_INS_BEFORE, 32'hA5A5_A5A5, '0);  // middle insert, cursor follows
        send_item(CMD_PREV,       32'h0, '0);
        send_item(CMD_RD_CUR,     32'h0, '0);
        send_item(CMD_WR_CUR,     32'h5A5A_5A5A, '0);
        send_item(CMD_RD_IDX,     32'h0, 10'd2);
        send_item(CMD_WR_IDX,     32'h1234_5678, 10'd0);
        send_item(CMD_RD_IDX,     32'h0, 10'd3);       // one past the end
        send_item(CMD_DELETE,     32'h0, '0);          // middle delete
        send_item(CMD_END,        32'h0, '0);
        send_item(CMD_DELETE,     32'h0, '0);          // last element, cursor steps back
        send_item(CMD_START,      32'h0, '0);
        send_item(CMD_PREV,       32'h0, '0);
        send_item(CMD_DELETE,     32'h0, '0);          // list empties, cursor stays 0
    endtask

    // Fill to DEPTH, hit the full cases and the longest shifts, then empty again.
    task automatic test_full_list();
        send_item(CMD_END, 32'h0, '0);
        // Inserting before the last element moves one word, so the fill is cheap.
        while (list_len < DEPTH) begin
            cmd_gap_max = (list_len < DEPTH / 3) ? 0 : MAX_WAIT;
            send_item(CMD_INS_BEFORE, $urandom(), POS_W'($urandom_range(0, POS_MAX)));
        end
        cmd_gap_max = MAX_WAIT;
        send_item(CMD_INS_BEFORE, $urandom(), '0);
        send_item(CMD_INS_AFTER,  $urandom(), '0);
        send_item(CMD_NEXT,       32'h0, '0);
        send_item(CMD_RD_IDX,     32'h0, POS_W'(POS_MAX));
        send_item(CMD_WR_IDX,     $urandom(), POS_W'(POS_MAX));
        send_item(CMD_RD_IDX,     32'h0, POS_W'(POS_MAX));
        send_item(CMD_START,      32'h0, '0);
        send_item(CMD_DELETE,     32'h0, '0);          // longest shift down
        send_item(CMD_INS_BEFORE, $urandom(), '0);     // longest shift up, full again
        send_item(CMD_RD_CUR,     32'h0, '0);
        send_item(CMD_RD_IDX,     32'h0, '0);
        // Sender holds off until the list has caught up with every command.
        wait_results_drained();
        send_item(CMD_END, 32'h0, '0);
        while (list_len > 0)
            send_item(CMD_DELETE, $urandom(), POS_W'($urandom_range(0, POS_MAX)));
    endtask

    // Mixed traffic in segments; each segment picks a target list size and a
    // throttle profile. Sizes stay mostly small to keep shifts short.
    task automatic test_random_mix();
        int                 sent;
        int                 target;
        int                 r;
        int                 pos;
        int                 k;
        t_cmd               c;
        logic [VALUE_W-1:0] v;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            target        = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 128)
                                                        : $urandom_range(1, 16);
            cmd_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
            res_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
            for (k = 0; k < SEGMENT_LEN && sent < RANDOM_ITEMS; k++) begin
                r   = $urandom_range(0, 99);
                v   = $urandom();
                pos = $urandom_range(0, POS_MAX);
                if (r < 35) begin
                    // steer the size toward the segment target
                    if (list_len < target)
                        c = $urandom_range(0, 1) ? CMD_INS_BEFORE : CMD_INS_AFTER;
                    else
                        c = CMD_DELETE;
                end else if (r < 45) begin
                    c = $urandom_range(0, 1) ? CMD_PREV : CMD_NEXT;
                end else if (r < 50) begin
                    c = $urandom_range(0, 1) ? CMD_START : CMD_END;
                end else if (r < 60) begin
                    c = $urandom_range(0, 1) ? CMD_RD_CUR : CMD_WR_CUR;
                end else if (r < 85) begin
                    c = $urandom_range(0, 1) ? CMD_RD_IDX : CMD_WR_IDX;
                    if (list_len > 0 && $urandom_range(0, 99) < 85)
                        pos = $urandom_range(0, list_len - 1);
                end else if (r < 95) begin
                    c = t_cmd'($urandom_range(0, (1 << CMD_W) - 1));   // noise
                end else begin
                    c = t_cmd'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                end
                send_item(c, v, POS_W'(pos));
                sent++;
            end
        end
        cmd_gap_max   = MAX_WAIT;
        res_stall_max = MAX_WAIT;
    endtask

    // Result sink: random stall per item, then take one result and check it
    // against the oldest prediction.
    initial begin : result_sink
        int           stall;
        t_list_result want;
        t_list_result got;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = $urandom_range(0, res_stall_max);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.read_data  = res_if.read_data;
            got.status     = res_if.status;
            got.length     = res_if.length;
            got.cursor_pos = res_if.cursor_pos;
            results_checked++;
            if (predicted_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("result %0d with nothing predicted: data=%h st=%0d len=%0d cur=%0d",
                             results_checked, got.read_data, got.status, got.length,
                             got.cursor_pos);
            end else begin
                want = predicted_results.pop_front();
                if (got.read_data !== want.read_data || got.status !== want.status ||
                    got.length !== want.length || got.cursor_pos !== want.cursor_pos) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result %0d mismatch: exp data=%h st=%0d len=%0d cur=%0d, got data=%h st=%0d len=%0d cur=%0d",
                                 results_checked, want.read_data, want.status, want.length,
                                 want.cursor_pos, got.read_data, got.status, got.length,
                                 got.cursor_pos);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        cmd_if.valid    <= 1'b0;
        cmd_if.cmd      <= CMD_INS_BEFORE;
        cmd_if.value    <= '0;
        cmd_if.position <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edit_ops();
        wait_results_drained();
        test_full_list();
        wait_results_drained();
        test_random_mix();

        wait_results_drained();
        if (predicted_results.size() != 0) begin
            fail_count += predicted_results.size();
            $display("%0d predicted results never arrived", predicted_results.size());
        end

        $display("Sent %0d command items, checked %0d results; list length peaked at %0d of %0d.",
                 items_sent, results_checked, peak_len, DEPTH);
        $display("Covered empty-list and full-list cases, full-depth shifts and throttled random traffic.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
